@@ hw/rtl/lswa_pkg.sv @@
package lswa_pkg;

  // Packet buffer depth, in points.
  localparam int unsigned PKT_POINTS = 48;
  localparam int unsigned PKT_IDX_W  = $clog2(PKT_POINTS);
  localparam int unsigned PKT_CNT_W  = $clog2(PKT_POINTS + 1);

  localparam logic [31:0] WINDOW_RST = 32'd100000000;

  localparam logic CMD_POINT = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic KIND_POINT  = 1'b0;
  localparam logic KIND_MARKER = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [63:0] packet_time_ns;
    logic [31:0] point_offset_ns;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] point_z;
    logic [31:0] point_intensity;
    logic [7:0]  point_tag;
    logic [7:0]  point_line;
    logic        packet_last;
  } in_req_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] scan_time_ns;
    logic [31:0] rebased_offset_ns;
    logic [31:0] out_x;
    logic [31:0] out_y;
    logic [31:0] out_z;
    logic [31:0] out_intensity;
    logic [7:0]  out_tag;
    logic [7:0]  out_line;
    logic        run_last;
  } out_res_t;

  // One buffered point.
  typedef struct packed {
    logic [31:0] offset;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] intensity;
    logic [7:0]  tag;
    logic [7:0]  line;
  } pkt_entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FLUSH,
    S_END,
    S_OLD,
    S_WIN,
    S_OPEN,
    S_RD,
    S_PT,
    S_ZMARK
  } lswa_state_t;

endpackage

@@ hw/rtl/lidar_scan_window_accumulator.sv @@
// Lidar scan window accumulator.
// Requests arrive on the in_ channel (valid/ready), one lidar point or one
// flush command per request. Results leave on the out_ channel (valid/ready):
// rebased points and scan-closed markers, with run_last set on the last result
// that a request causes. The window length is written through cfg_we and
// cfg_wdata; the user must write it only while the block is idle, which the
// block does not enforce. A point that is not the last of its packet is
// stored in the packet buffer, if not full, in the cycle it is accepted and
// causes no result. A last point starts a sequence around one shared 64-bit
// adder/subtractor: packet end, age check against the scan start, window
// check, then the scan is opened if needed; then each buffered point gets a
// buffer read, then a rebase add into the output register. Age and window
// markers leave from their check steps; a zero window adds a final marker.
// A flush emits its marker only if a scan is open, else it causes no result.
// in_ready is high only while the sequencer is idle; the output register lets
// the next request be accepted while the last result still waits.
// If the receiver stalls, the sequencer holds until the output register is
// free, so no result is lost or repeated.
// Reset (rst_n low at a clock edge) closes the scan, empties the packet buffer
// and sets the window to 100 ms; the buffer contents themselves are not cleared.
module lidar_scan_window_accumulator
  import lswa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_req_t     in_req,
  output logic        out_valid,
  input  logic        out_ready,
  output out_res_t    out_res,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  lswa_state_t          state_r, state_nxt;
  logic                 scan_open_r, scan_open_nxt;
  logic [63:0]          scan_start_r, scan_start_nxt;
  logic [PKT_CNT_W-1:0] pkt_count_r, pkt_count_nxt;
  logic [31:0]          pkt_max_r, pkt_max_nxt;
  logic [63:0]          pkt_time_r, pkt_time_nxt;
  logic [63:0]          end_r, end_nxt;
  logic [63:0]          diff_r, diff_nxt;
  logic [63:0]          base_r, base_nxt;
  logic [PKT_IDX_W-1:0] idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_res_t             out_res_r, out_res_nxt;
  logic [31:0]          window_r;

  // Packet buffer.
  pkt_entry_t           pkt_mem [PKT_POINTS];
  pkt_entry_t           rd_data_r;
  pkt_entry_t           wr_data;
  logic                 mem_we;

  // Shared adder/subtractor. Bit 64 is carry for add and borrow for subtract.
  logic [63:0]          alu_a, alu_b;
  logic                 alu_sub;
  logic [64:0]          alu_res;

  logic                 slot_free;
  logic                 accept;
  logic                 win_exceeded;
  logic                 pt_last;
  logic                 rebase_sat;

  assign alu_res   = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                             : ({1'b0, alu_a} + {1'b0, alu_b});
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // The window check is valid only in the window state, where the adder
  // computes packet end minus scan start; a borrow means end is not later.
  assign win_exceeded = scan_open_r && (window_r != 32'd0) && !alu_res[64] &&
                        ((alu_res[63:32] != 32'd0) || (alu_res[31:0] > window_r));
  assign pt_last      = ((PKT_CNT_W'(idx_r) + PKT_CNT_W'(1)) == pkt_count_r);
  assign rebase_sat   = alu_res[64] || (alu_res[63:32] != 32'd0);

  assign wr_data = '{offset:    in_req.point_offset_ns,
                     x:         in_req.point_x,
                     y:         in_req.point_y,
                     z:         in_req.point_z,
                     intensity: in_req.point_intensity,
                     tag:       in_req.point_tag,
                     line:      in_req.point_line};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pkt_mem[pkt_count_r[PKT_IDX_W-1:0]] <= wr_data;
    end
    rd_data_r <= pkt_mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_open_r <= 1'b0;
      scan_start_r <= 64'd0;
      pkt_count_r <= '0;
      pkt_max_r   <= 32'd0;
      pkt_time_r  <= 64'd0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      window_r    <= WINDOW_RST;
    end else begin
      state_r     <= state_nxt;
      scan_open_r <= scan_open_nxt;
      scan_start_r <= scan_start_nxt;
      pkt_count_r <= pkt_count_nxt;
      pkt_max_r   <= pkt_max_nxt;
      pkt_time_r  <= pkt_time_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        window_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    end_r     <= end_nxt;
    diff_r    <= diff_nxt;
    base_r    <= base_nxt;
    out_res_r <= out_res_nxt;
  end

  always_comb begin
    out_res_t marker;

    state_nxt      = state_r;
    scan_open_nxt  = scan_open_r;
    scan_start_nxt = scan_start_r;
    pkt_count_nxt  = pkt_count_r;
    pkt_max_nxt    = pkt_max_r;
    pkt_time_nxt   = pkt_time_r;
    end_nxt        = end_r;
    diff_nxt       = diff_r;
    base_nxt       = base_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = out_ready ? 1'b0 : out_valid_r;
    out_res_nxt    = out_res_r;
    mem_we         = 1'b0;
    alu_a          = pkt_time_r;
    alu_b          = scan_start_r;
    alu_sub        = 1'b1;

    // A marker carries only the start time of the scan it closes.
    marker              = '0;
    marker.kind         = KIND_MARKER;
    marker.scan_time_ns = scan_start_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_req.cmd == CMD_FLUSH) begin
            if (scan_open_r) begin
              state_nxt = S_FLUSH;
            end
          end else begin
            if (pkt_count_r < PKT_CNT_W'(PKT_POINTS)) begin
              mem_we        = 1'b1;
              pkt_count_nxt = pkt_count_r + PKT_CNT_W'(1);
              if (pkt_count_r == '0) begin
                pkt_time_nxt = in_req.packet_time_ns;
                pkt_max_nxt  = in_req.point_offset_ns;
              end else if (in_req.point_offset_ns > pkt_max_r) begin
                pkt_max_nxt = in_req.point_offset_ns;
              end
            end
            if (in_req.packet_last) begin
              state_nxt = S_END;
            end
          end
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          out_valid_nxt   = 1'b1;
          out_res_nxt     = marker;
          out_res_nxt.run_last = 1'b1;
          scan_open_nxt   = 1'b0;
          scan_start_nxt  = 64'd0;
          state_nxt       = S_IDLE;
        end
      end
      S_END: begin
        // Packet end, saturating at the top of the 64-bit range.
        alu_a   = pkt_time_r;
        alu_b   = {32'd0, pkt_max_r};
        alu_sub = 1'b0;
        end_nxt = alu_res[64] ? '1 : alu_res[63:0];
        state_nxt = S_OLD;
      end
      S_OLD: begin
        // A borrow here means the packet is older than the open scan.
        alu_a    = pkt_time_r;
        alu_b    = scan_start_r;
        diff_nxt = alu_res[63:0];
        if (scan_open_r && alu_res[64]) begin
          if (slot_free) begin
            out_valid_nxt  = 1'b1;
            out_res_nxt    = marker;
            scan_open_nxt  = 1'b0;
            scan_start_nxt = 64'd0;
            state_nxt      = S_WIN;
          end
        end else begin
          state_nxt = S_WIN;
        end
      end
      S_WIN: begin
        alu_a = end_r;
        alu_b = scan_start_r;
        if (win_exceeded) begin
          if (slot_free) begin
            out_valid_nxt  = 1'b1;
            out_res_nxt    = marker;
            scan_open_nxt  = 1'b0;
            scan_start_nxt = 64'd0;
            state_nxt      = S_OPEN;
          end
        end else begin
          state_nxt = S_OPEN;
        end
      end
      S_OPEN: begin
        // An open scan here started no later than the packet, so the
        // difference from the age check is the rebase amount.
        if (!scan_open_r) begin
          scan_open_nxt  = 1'b1;
          scan_start_nxt = pkt_time_r;
          base_nxt       = 64'd0;
        end else begin
          base_nxt = diff_r;
        end
        idx_nxt   = '0;
        state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_PT;
      end
      S_PT: begin
        alu_a   = base_r;
        alu_b   = {32'd0, rd_data_r.offset};
        alu_sub = 1'b0;
        if (slot_free) begin
          out_valid_nxt                 = 1'b1;
          out_res_nxt.kind              = KIND_POINT;
          out_res_nxt.scan_time_ns      = scan_start_r;
          out_res_nxt.rebased_offset_ns = rebase_sat ? '1 : alu_res[31:0];
          out_res_nxt.out_x             = rd_data_r.x;
          out_res_nxt.out_y             = rd_data_r.y;
          out_res_nxt.out_z             = rd_data_r.z;
          out_res_nxt.out_intensity     = rd_data_r.intensity;
          out_res_nxt.out_tag           = rd_data_r.tag;
          out_res_nxt.out_line          = rd_data_r.line;
          out_res_nxt.run_last          = pt_last && (window_r != 32'd0);
          idx_nxt                       = idx_r + PKT_IDX_W'(1);
          if (!pt_last) begin
            state_nxt = S_RD;
          end else if (window_r == 32'd0) begin
            state_nxt = S_ZMARK;
          end else begin
            pkt_count_nxt = '0;
            pkt_max_nxt   = 32'd0;
            state_nxt     = S_IDLE;
          end
        end
      end
      S_ZMARK: begin
        if (slot_free) begin
          out_valid_nxt        = 1'b1;
          out_res_nxt          = marker;
          out_res_nxt.run_last = 1'b1;
          scan_open_nxt        = 1'b0;
          scan_start_nxt       = 64'd0;
          pkt_count_nxt        = '0;
          pkt_max_nxt          = 32'd0;
          state_nxt            = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
